/* hdl/three_mic_sound_onset_capture_assert.svh */
// Assertion macros for the onset capture block.
// The asserting module provides clk and rst_n.
`ifndef THREE_MIC_SOUND_ONSET_CAPTURE_ASSERT_SVH
`define THREE_MIC_SOUND_ONSET_CAPTURE_ASSERT_SVH

`ifndef ASSERT_OFF

`define TMSOC_ASSERT_IMPL(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

`define TMSOC_ASSERT_NEXT(lbl, lhs, rhs) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TMSOC_ASSERT_IMPL(lbl, lhs, rhs)

`define TMSOC_ASSERT_NEXT(lbl, lhs, rhs)

`endif

`endif

/* hdl/tmsoc_pkg.sv */
package tmsoc_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int THR_W       = 10;
    localparam int BUF_W       = 13;
    localparam int BASE_W      = 18;
    localparam int AVG_W       = 17;
    localparam int POS_W       = 12;
    localparam int SEL_W       = 3;
    localparam int CNT_W       = 8;
    localparam int SCALE_SHIFT = 7;
    localparam int NUM_THR     = 5;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] PHASE_WARMUP  = 2'd0;
    localparam logic [1:0] PHASE_LISTEN  = 2'd1;
    localparam logic [1:0] PHASE_CAPTURE = 2'd2;

    localparam logic [2:0] REG_THR_1  = 3'd0;
    localparam logic [2:0] REG_THR_2  = 3'd1;
    localparam logic [2:0] REG_THR_3  = 3'd2;
    localparam logic [2:0] REG_THR_4  = 3'd3;
    localparam logic [2:0] REG_THR_5  = 3'd4;
    localparam logic [2:0] REG_BUFFER = 3'd5;

    localparam logic [THR_W-1:0] THR_1_RESET = 10'd10;
    localparam logic [THR_W-1:0] THR_2_RESET = 10'd20;
    localparam logic [THR_W-1:0] THR_3_RESET = 10'd30;
    localparam logic [THR_W-1:0] THR_4_RESET = 10'd40;
    localparam logic [THR_W-1:0] THR_5_RESET = 10'd50;
    localparam logic [BUF_W-1:0] BUFFER_RESET = 13'd256;
    localparam logic [BUF_W-1:0] BUFFER_MIN   = 13'd3;
    localparam logic [BUF_W-1:0] BUFFER_MAX   = 13'd4096;
    localparam logic [SEL_W-1:0] SEL_RESET    = 3'd2;
    localparam logic [SEL_W-1:0] SEL_LAST     = 3'd4;

    typedef struct packed {
        logic [1:0]                 phase;
        logic                       onset;
        logic                       record_valid;
        logic [POS_W-1:0]           record_index;
        logic signed [SAMPLE_W-1:0] record_left;
        logic signed [SAMPLE_W-1:0] record_back;
        logic signed [SAMPLE_W-1:0] record_right;
        logic                       capture_done;
        logic signed [AVG_W-1:0]    average_left;
        logic signed [AVG_W-1:0]    average_back;
        logic signed [AVG_W-1:0]    average_right;
        logic [SEL_W-1:0]           threshold_choice;
    } result_t;

endpackage

/* hdl/three_mic_sound_onset_capture.sv */
// Sound onset capture for three microphones. Each input beat carries a
// command in s_tuser and, for a sample set, three signed 10-bit samples in
// s_tdata; every beat produces exactly one result beat. The block warms up
// over AVERAGE_COUNT+1 sample sets, then compares each sample against its
// leaky average minus the selected threshold (times 128); an onset starts a
// capture of buffer_size-2 records (buffer_size clamped to 3..4096) with
// the averages frozen, the last one marked by m_tlast. Throughput is one
// beat per clock while m_tready is high; the averages, counters and
// threshold choice are updated between an input register and a result
// register. s_tready drops only when both stages are full and m_tready is low.
// The division by AVERAGE_COUNT is a constant reciprocal multiply, six in
// parallel per beat. Registers: threshold_1..5 at 0x00..0x10,
// buffer_size at 0x14.
`include "three_mic_sound_onset_capture_assert.svh"

module three_mic_sound_onset_capture
    import tmsoc_pkg::*;
#(
    parameter int AVERAGE_COUNT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mic_left, mic_back, mic_right, 2 zero bits
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // record_index, record_left, record_back,
                                   // record_right, average_left, average_back,
                                   // average_right, threshold_choice
    output logic [3:0]  m_tuser,   // phase, onset, record_valid
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DIV_LOG   = $clog2(AVERAGE_COUNT);
    localparam int DIV_SHIFT = BASE_W + DIV_LOG;
    localparam int MULT_W    = BASE_W + 2;
    localparam int PROD_W    = BASE_W + MULT_W;
    localparam longint DIV_MULT_L =
        ((longint'(1) <<< DIV_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);
    localparam logic [CNT_W-1:0] WARMUP_LAST = CNT_W'(AVERAGE_COUNT);

    function automatic logic signed [BASE_W-1:0] div_n(input logic signed [BASE_W-1:0] v);
        logic [BASE_W-1:0] mag;
        logic [PROD_W-1:0] prod;
        logic [BASE_W-1:0] q;
        mag  = v[BASE_W-1] ? (~v + 1'b1) : v;
        prod = PROD_W'(mag) * PROD_W'(DIV_MULT);
        q    = BASE_W'(prod >> DIV_SHIFT);
        return v[BASE_W-1] ? BASE_W'(~q + 1'b1) : q;
    endfunction

    function automatic logic signed [BASE_W-1:0] leak(input logic signed [BASE_W-1:0] avg,
                                                       input logic signed [BASE_W-1:0] s);
        logic signed [BASE_W:0] sum;
        sum = (BASE_W+1)'(div_n(s)) + (BASE_W+1)'(avg) - (BASE_W+1)'(div_n(avg));
        return sum[BASE_W-1:0];
    endfunction

    logic [THR_W-1:0] thr1_reg, thr2_reg, thr3_reg, thr4_reg, thr5_reg;
    logic [BUF_W-1:0] buf_reg;

    logic                       in_valid_reg;
    logic [1:0]                 in_cmd_reg;
    logic signed [SAMPLE_W-1:0] in_left_reg, in_back_reg, in_right_reg;

    logic signed [BASE_W-1:0] base_left_reg, base_back_reg, base_right_reg;
    logic signed [BASE_W-1:0] base_left_next, base_back_next, base_right_next;
    logic [CNT_W-1:0]         warm_reg, warm_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [SEL_W-1:0]         sel_reg, sel_next;

    logic    out_valid_reg;
    result_t out_reg, res_next;

    logic advance;
    logic cfg_write;

    logic signed [BASE_W-1:0] s_left, s_back, s_right;
    logic signed [19:0]       thr_scaled;
    logic [THR_W-1:0]         thr_live;
    logic [BUF_W-1:0]         lim, pos_inc;
    logic                     below;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            REG_THR_1:  prdata = 32'(thr1_reg);
            REG_THR_2:  prdata = 32'(thr2_reg);
            REG_THR_3:  prdata = 32'(thr3_reg);
            REG_THR_4:  prdata = 32'(thr4_reg);
            REG_THR_5:  prdata = 32'(thr5_reg);
            REG_BUFFER: prdata = 32'(buf_reg);
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr1_reg <= THR_1_RESET;
            thr2_reg <= THR_2_RESET;
            thr3_reg <= THR_3_RESET;
            thr4_reg <= THR_4_RESET;
            thr5_reg <= THR_5_RESET;
            buf_reg  <= BUFFER_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_THR_1:  thr1_reg <= pwdata[THR_W-1:0];
                REG_THR_2:  thr2_reg <= pwdata[THR_W-1:0];
                REG_THR_3:  thr3_reg <= pwdata[THR_W-1:0];
                REG_THR_4:  thr4_reg <= pwdata[THR_W-1:0];
                REG_THR_5:  thr5_reg <= pwdata[THR_W-1:0];
                REG_BUFFER: buf_reg  <= pwdata[BUF_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (sel_reg)
            REG_THR_2: thr_live = thr2_reg;
            REG_THR_3: thr_live = thr3_reg;
            REG_THR_4: thr_live = thr4_reg;
            REG_THR_5: thr_live = thr5_reg;
            default:   thr_live = thr1_reg;
        endcase
    end

    assign s_left     = BASE_W'(signed'({in_left_reg, {SCALE_SHIFT{1'b0}}}));
    assign s_back     = BASE_W'(signed'({in_back_reg, {SCALE_SHIFT{1'b0}}}));
    assign s_right    = BASE_W'(signed'({in_right_reg, {SCALE_SHIFT{1'b0}}}));
    assign thr_scaled = 20'({thr_live, {SCALE_SHIFT{1'b0}}});

    assign below = (20'(s_left)  < 20'(base_left_reg)  - thr_scaled) ||
                   (20'(s_back)  < 20'(base_back_reg)  - thr_scaled) ||
                   (20'(s_right) < 20'(base_right_reg) - thr_scaled);

    assign lim     = (buf_reg < BUFFER_MIN) ? BUFFER_MIN :
                     (buf_reg > BUFFER_MAX) ? BUFFER_MAX : buf_reg;
    assign pos_inc = BUF_W'(pos_reg) + 1'b1;

    always_comb
    begin
        base_left_next  = base_left_reg;
        base_back_next  = base_back_reg;
        base_right_next = base_right_reg;
        warm_next       = warm_reg;
        pos_next        = pos_reg;
        sel_next        = sel_reg;
        res_next        = '0;

        case (in_cmd_reg)
            CMD_STEP:
            begin
                sel_next = (sel_reg >= SEL_LAST) ? '0 : sel_reg + 1'b1;
            end
            CMD_RESTART:
            begin
                warm_next = '0;
            end
            CMD_SAMPLE:
            begin
                if (pos_reg != '0)
                begin
                    res_next.record_valid = 1'b1;
                    res_next.record_index = pos_reg;
                    res_next.record_left  = in_left_reg;
                    res_next.record_back  = in_back_reg;
                    res_next.record_right = in_right_reg;
                    if (pos_inc >= lim - 1'b1)
                    begin
                        pos_next              = '0;
                        res_next.capture_done = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
                else if (warm_reg <= WARMUP_LAST)
                begin
                    base_left_next  = leak(base_left_reg, s_left);
                    base_back_next  = leak(base_back_reg, s_back);
                    base_right_next = leak(base_right_reg, s_right);
                    warm_next       = warm_reg + 1'b1;
                end
                else if (below)
                begin
                    res_next.onset = 1'b1;
                    pos_next       = POS_W'(1);
                end
                else
                begin
                    base_left_next  = leak(base_left_reg, s_left);
                    base_back_next  = leak(base_back_reg, s_back);
                    base_right_next = leak(base_right_reg, s_right);
                end
            end
            default: ;
        endcase

        if (pos_next != '0)
            res_next.phase = PHASE_CAPTURE;
        else if (warm_next <= WARMUP_LAST)
            res_next.phase = PHASE_WARMUP;
        else
            res_next.phase = PHASE_LISTEN;

        res_next.average_left     = base_left_next[AVG_W-1:0];
        res_next.average_back     = base_back_next[AVG_W-1:0];
        res_next.average_right    = base_right_next[AVG_W-1:0];
        res_next.threshold_choice = sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            base_left_reg  <= '0;
            base_back_reg  <= '0;
            base_right_reg <= '0;
            warm_reg       <= '0;
            pos_reg        <= '0;
            sel_reg        <= SEL_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
            begin
                base_left_reg  <= base_left_next;
                base_back_reg  <= base_back_next;
                base_right_reg <= base_right_next;
                warm_reg       <= warm_next;
                pos_reg        <= pos_next;
                sel_reg        <= sel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= s_tuser;
            in_left_reg  <= s_tdata[9:0];
            in_back_reg  <= s_tdata[19:10];
            in_right_reg <= s_tdata[29:20];
        end
        if (advance && in_valid_reg)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.record_valid, out_reg.onset, out_reg.phase};
    assign m_tlast  = out_reg.capture_done;
    assign m_tdata  = {out_reg.threshold_choice,
                       out_reg.average_right, out_reg.average_back, out_reg.average_left,
                       out_reg.record_right, out_reg.record_back, out_reg.record_left,
                       out_reg.record_index};

    `TMSOC_ASSERT_IMPL(a_stall_only_on_full, in_valid_reg && !s_tready, m_tvalid && !m_tready)
    `TMSOC_ASSERT_IMPL(a_onset_starts_capture, m_tvalid && m_tuser[2], m_tuser[1:0] == PHASE_CAPTURE)
    `TMSOC_ASSERT_IMPL(a_done_is_record, m_tvalid && m_tlast, m_tuser[3] && !m_tuser[2])
    `TMSOC_ASSERT_NEXT(a_onset_first_pos, advance && in_valid_reg && res_next.onset, pos_reg == POS_W'(1))

endmodule

/* verif/tb_top.sv */
module tb_top;
    import tmsoc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_N = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_SETTINGS = 12;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class onset_capture_model;
        int thr[NUM_THR];
        int buf_size;
        int base_l;
        int base_b;
        int base_r;
        int warm_cnt;
        int cap_pos;
        int sel;
        result_t pending_results[$];
        int mismatches;
        int results_seen;

        function new();
            thr[0] = THR_1_RESET;
            thr[1] = THR_2_RESET;
            thr[2] = THR_3_RESET;
            thr[3] = THR_4_RESET;
            thr[4] = THR_5_RESET;
            buf_size = BUFFER_RESET;
            base_l = 0;
            base_b = 0;
            base_r = 0;
            warm_cnt = 0;
            cap_pos = 0;
            sel = SEL_RESET;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_register(logic [2:0] idx, logic [31:0] val);
            if (idx == REG_BUFFER)
                buf_size = val[BUF_W-1:0];
            else if (idx <= REG_THR_5)
                thr[idx] = val[THR_W-1:0];
        endfunction

        function int leak(int avg, int s);
            return s / AVG_N + avg - avg / AVG_N;
        endfunction

        function void fold_scan(logic [1:0] cmd, logic [9:0] l, logic [9:0] b, logic [9:0] r);
            result_t exp;
            int sl;
            int sb;
            int sr;
            int lim;
            int th;
            int idx;
            bit onset;
            bit rec;
            bit done;
            exp = '0;
            onset = 0;
            rec = 0;
            done = 0;
            idx = 0;
            sl = $signed(l);
            sb = $signed(b);
            sr = $signed(r);
            sl = sl * 128;
            sb = sb * 128;
            sr = sr * 128;
            if (cmd == CMD_STEP) begin
                sel = (sel >= SEL_LAST) ? 0 : sel + 1;
            end
            else if (cmd == CMD_RESTART) begin
                warm_cnt = 0;
            end
            else if (cmd == CMD_SAMPLE) begin
                if (cap_pos != 0) begin
                    lim = buf_size;
                    if (lim < BUFFER_MIN)
                        lim = BUFFER_MIN;
                    if (lim > BUFFER_MAX)
                        lim = BUFFER_MAX;
                    rec = 1;
                    idx = cap_pos;
                    cap_pos++;
                    if (cap_pos >= lim - 1) begin
                        cap_pos = 0;
                        done = 1;
                    end
                end
                else if (warm_cnt <= AVG_N) begin
                    base_l = leak(base_l, sl);
                    base_b = leak(base_b, sb);
                    base_r = leak(base_r, sr);
                    warm_cnt = (warm_cnt + 1) & 255;
                end
                else begin
                    th = thr[sel] * 128;
                    if (sl < base_l - th || sb < base_b - th || sr < base_r - th) begin
                        onset = 1;
                        cap_pos = 1;
                    end
                    else begin
                        base_l = leak(base_l, sl);
                        base_b = leak(base_b, sb);
                        base_r = leak(base_r, sr);
                    end
                end
            end
            if (cap_pos != 0)
                exp.phase = PHASE_CAPTURE;
            else if (warm_cnt <= AVG_N)
                exp.phase = PHASE_WARMUP;
            else
                exp.phase = PHASE_LISTEN;
            exp.onset = onset;
            exp.record_valid = rec;
            if (rec) begin
                exp.record_index = idx[POS_W-1:0];
                exp.record_left = l;
                exp.record_back = b;
                exp.record_right = r;
                exp.capture_done = done;
            end
            exp.average_left = base_l[AVG_W-1:0];
            exp.average_back = base_b[AVG_W-1:0];
            exp.average_right = base_r[AVG_W-1:0];
            exp.threshold_choice = sel[SEL_W-1:0];
            pending_results.push_back(exp);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d %s: expected %0h, got %0h",
                             results_seen, name, want, seen);
            end
        endfunction

        function void compare_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected", results_seen);
            end
            else begin
                exp = pending_results.pop_front();
                check_field("phase", exp.phase, got.phase);
                check_field("onset", exp.onset, got.onset);
                check_field("record_valid", exp.record_valid, got.record_valid);
                check_field("record_index", exp.record_index, got.record_index);
                check_field("record_left", exp.record_left, got.record_left);
                check_field("record_back", exp.record_back, got.record_back);
                check_field("record_right", exp.record_right, got.record_right);
                check_field("capture_done", exp.capture_done, got.capture_done);
                check_field("average_left", exp.average_left, got.average_left);
                check_field("average_back", exp.average_back, got.average_back);
                check_field("average_right", exp.average_right, got.average_right);
                check_field("threshold_choice", exp.threshold_choice, got.threshold_choice);
            end
            results_seen++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    onset_capture_model model = new();
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int level = 0;
    result_t got;

    three_mic_sound_onset_capture #(.AVERAGE_COUNT(AVG_N)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            got.phase = m_tuser[1:0];
            got.onset = m_tuser[2];
            got.record_valid = m_tuser[3];
            got.record_index = m_tdata[11:0];
            got.record_left = m_tdata[21:12];
            got.record_back = m_tdata[31:22];
            got.record_right = m_tdata[41:32];
            got.average_left = m_tdata[58:42];
            got.average_back = m_tdata[75:59];
            got.average_right = m_tdata[92:76];
            got.threshold_choice = m_tdata[95:93];
            got.capture_done = m_tlast;
            model.compare_result(got);
        end
        if (rst_n && s_tvalid && s_tready)
            model.fold_scan(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[29:20]);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [9:0] near_level(int lvl);
        int n;
        int v;
        n = $urandom_range(8);
        v = lvl + n - 4;
        if (v > 511)
            v = 511;
        if (v < -512)
            v = -512;
        return v[9:0];
    endfunction

    function automatic logic [9:0] rand_sample();
        return 10'($urandom_range(1023));
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [9:0] l,
                             input logic [9:0] b, input logic [9:0] r);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {2'b00, r, b, l};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_quiet();
        send_beat(CMD_SAMPLE, near_level(level), near_level(level), near_level(level));
    endtask

    task automatic send_drop();
        int mask;
        logic [9:0] v[3];
        mask = $urandom_range(1, 7);
        for (int i = 0; i < 3; i++)
            v[i] = mask[i] ? near_level(-512 + $urandom_range(300)) : near_level(level);
        send_beat(CMD_SAMPLE, v[0], v[1], v[2]);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        model.write_register(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic warm_up_run();
        level = $urandom_range(80);
        level = level - 20;
        send_beat(CMD_RESTART, rand_sample(), rand_sample(), rand_sample());
        repeat (AVG_N + 2) send_quiet();
    endtask

    task automatic listen_run();
        int len;
        int lead;
        len = $urandom_range(3, 25);
        repeat (len) send_quiet();
        if ($urandom_range(99) < 60) begin
            send_drop();
            if ($urandom_range(99) < 25) begin
                lead = $urandom_range(3);
                repeat (lead) send_quiet();
                send_beat(CMD_RESTART, rand_sample(), rand_sample(), rand_sample());
            end
        end
    endtask

    task automatic apply_setting(input int k, input logic [12:0] bsize);
        logic [31:0] v;
        for (int i = 0; i < NUM_THR; i++) begin
            if (k == 0)
                v = 0;
            else if (k == 1)
                v = 1023;
            else if ($urandom_range(9) == 0)
                v = $urandom_range(1023);
            else
                v = $urandom_range(60);
            write_reg(3'(REG_THR_1 + i), v);
        end
        write_reg(REG_BUFFER, 32'(bsize));
    endtask

    initial
    begin
        logic [12:0] bsizes[NUM_SETTINGS];
        int budget;
        int start;
        int pick;
        bsizes = '{13'd0, 13'd3, 13'd1, 13'd8191, 13'd2, 13'd5,
                   13'd4, 13'd4096, 13'd9, 13'd17, 13'd6, 13'd3};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF);
        repeat (6) send_beat(CMD_STEP, 10'h000, 10'h000, 10'h000);
        send_beat(CMD_RESTART, 10'h000, 10'h000, 10'h000);
        send_beat(CMD_SAMPLE, 10'h1FF, 10'h1FF, 10'h1FF);
        send_beat(CMD_SAMPLE, 10'h200, 10'h200, 10'h200);
        send_beat(CMD_SAMPLE, 10'h1FF, 10'h200, 10'h000);
        send_beat(CMD_SAMPLE, 10'h3FF, 10'h000, 10'h200);
        send_beat(CMD_RESTART, 10'h155, 10'h2AA, 10'h155);
        send_beat(CMD_UNUSED, 10'h000, 10'h000, 10'h000);

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            drain();
            apply_setting(k, bsizes[k]);
            case (k % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            budget = (bsizes[k] > 13'd4000) ? 400 : 120;
            start = items_sent;
            warm_up_run();
            while (items_sent - start < budget) begin
                pick = $urandom_range(99);
                if (pick < 8)
                    warm_up_run();
                else if (pick < 72)
                    listen_run();
                else if (pick < 80)
                    send_beat(CMD_STEP, rand_sample(), rand_sample(), rand_sample());
                else if (pick < 92)
                    send_beat(2'($urandom_range(3)), rand_sample(), rand_sample(),
                              rand_sample());
                else
                    send_beat(CMD_UNUSED, rand_sample(), rand_sample(), rand_sample());
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
